/* rtl/tpc_pkg.sv */
// Shared types and constants for the timer prescaler / period calculator.
// No dependencies; used by timer_prescaler_period_calc_top.
`default_nettype none

package tpc_pkg;

  localparam int unsigned FREQ_W          = 32;
  localparam int unsigned CLK_W           = 31;
  localparam int unsigned MAXP_W          = 16;
  localparam int unsigned PERIOD_W        = 16;
  localparam int unsigned CODE_W          = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  localparam int unsigned PRESCALER_STEPS = 256;
  localparam int unsigned CODE_MAX        = 255;

  // Divider counter must also hold PRESCALER_STEPS itself
  localparam int unsigned D_W    = $clog2(PRESCALER_STEPS + 1);
  // Multiplier operand is period_limit + 1
  localparam int unsigned MULT_W = MAXP_W + 1;
  // One counter serves the multiply and divide loops; the divide is longer
  localparam int unsigned CNT_W  = $clog2(CLK_W);

  localparam logic [CLK_W-1:0]  CORE_CLOCK_RST   = CLK_W'(72000000);
  localparam logic [MAXP_W-1:0] PERIOD_LIMIT_RST = MAXP_W'(65535);

  // Register index, taken from paddr[2]
  localparam logic REG_CORE_CLOCK   = 1'b0;
  localparam logic REG_PERIOD_LIMIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SRCH,
    S_DIV1,
    S_DIV2,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/timer_prescaler_period_calc_top.sv */
// Timer prescaler and period calculator, top level.
// Depends on tpc_pkg (types, widths, register indexes).
//
// One item (a requested frequency) is taken at a time; the result is
// (period, prescaler_code, status). Odd requests are rounded down to even.
// The divider d is searched from 1 upward with the test
// core_clock < (period_limit + 1) * f * d, which matches
// core_clock / (f * d) <= period_limit without a divide. The constant
// (period_limit + 1) * f is built by a bit-serial shift-add, the search adds
// it once per cycle, and the period (core_clock / d) / f comes from one
// restoring divider used twice, one quotient bit per cycle. A request that
// is zero after rounding goes straight to the result. The block stalls its
// input while it works; a finished result sits in the output register and
// the next item can be accepted while it waits.
`default_nettype none

module timer_prescaler_period_calc_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tpc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [tpc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [tpc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [tpc_pkg::FREQ_W-1:0]         freq_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [tpc_pkg::PERIOD_W-1:0]       period_o,
  output logic      [tpc_pkg::CODE_W-1:0]         prescaler_code_o,
  output logic      [tpc_pkg::STATUS_W-1:0]       status_o
);

  localparam int unsigned FW = tpc_pkg::FREQ_W;
  localparam int unsigned CW = tpc_pkg::CLK_W;

  // Configuration registers
  logic [CW-1:0]                  core_clock_q;
  logic [tpc_pkg::MAXP_W-1:0]     period_limit_q;

  // Control
  tpc_pkg::state_e                state_q, state_d;
  logic [tpc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;

  // Datapath
  logic [FW-1:0]                  f_q, f_d;
  logic [FW-1:0]                  acc_q, acc_d;
  logic                           sat_q, sat_d;
  logic [FW-1:0]                  k_q, k_d;
  logic [tpc_pkg::MULT_W-1:0]     mp_q, mp_d;
  logic [tpc_pkg::D_W-1:0]        d_q, d_d;
  logic [CW-1:0]                  dvd_q, dvd_d;
  logic [FW-1:0]                  rem_q, rem_d;
  logic [FW-1:0]                  dsr_q, dsr_d;
  tpc_pkg::status_e               st_q, st_d;

  logic [tpc_pkg::PERIOD_W-1:0]   out_period_q, out_period_d;
  logic [tpc_pkg::CODE_W-1:0]     out_code_q, out_code_d;
  tpc_pkg::status_e               out_status_q, out_status_d;

  // Step logic
  logic                           in_acc;
  logic                           cfg_wr;
  logic [FW-1:0]                  f_even;
  logic [FW+1:0]                  mul_sum;
  logic                           mul_sat;
  logic                           hit;
  logic [31:0]                    code_full;
  logic                           code_over;
  logic [FW:0]                    div_r;
  logic [FW:0]                    div_diff;
  logic                           div_ge;
  logic [CW-1:0]                  div_q;
  logic [FW-1:0]                  div_rem;
  logic                           out_free;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      tpc_pkg::REG_CORE_CLOCK:   prdata = {1'b0, core_clock_q};
      tpc_pkg::REG_PERIOD_LIMIT: prdata = {16'd0, period_limit_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_clock_q   <= tpc_pkg::CORE_CLOCK_RST;
      period_limit_q <= tpc_pkg::PERIOD_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == tpc_pkg::REG_CORE_CLOCK) begin
        core_clock_q <= pwdata[CW-1:0];
      end else begin
        period_limit_q <= pwdata[tpc_pkg::MAXP_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Serial arithmetic
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != tpc_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign f_even     = {freq_i[FW-1:1], 1'b0};

  // Shift-add multiply, MSB of (period_limit + 1) first, saturating past 32 bits
  assign mul_sum = {1'b0, acc_q, 1'b0} +
                   {2'b00, (mp_q[tpc_pkg::MULT_W-1] ? f_q : {FW{1'b0}})};
  assign mul_sat = sat_q || (mul_sum[FW+1:FW] != 2'b00);

  // Divider d accepted when core_clock < (period_limit + 1) * f * d
  assign hit       = sat_q || ({1'b0, core_clock_q} < acc_q);
  assign code_full = 32'(d_q) - 32'd1;
  assign code_over = code_full > 32'(tpc_pkg::CODE_MAX);

  // Restoring division, one quotient bit per cycle into the dividend register
  assign div_r    = {rem_q, dvd_q[CW-1]};
  assign div_diff = div_r - {1'b0, dsr_q};
  assign div_ge   = (div_r >= {1'b0, dsr_q});
  assign div_rem  = div_ge ? div_diff[FW-1:0] : div_r[FW-1:0];
  assign div_q    = {dvd_q[CW-2:0], div_ge};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    f_d          = f_q;
    acc_d        = acc_q;
    sat_d        = sat_q;
    k_d          = k_q;
    mp_d         = mp_q;
    d_d          = d_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    dsr_d        = dsr_q;
    st_d         = st_q;
    out_period_d = out_period_q;
    out_code_d   = out_code_q;
    out_status_d = out_status_q;

    unique case (state_q)
      tpc_pkg::S_IDLE: begin
        if (in_acc) begin
          f_d   = f_even;
          acc_d = '0;
          sat_d = 1'b0;
          mp_d  = {1'b0, period_limit_q} + tpc_pkg::MULT_W'(1);
          cnt_d = '0;
          d_d   = tpc_pkg::D_W'(1);
          if (f_even == '0) begin
            st_d    = tpc_pkg::ST_ZERO;
            state_d = tpc_pkg::S_DONE;
          end else begin
            state_d = tpc_pkg::S_MUL;
          end
        end
      end

      tpc_pkg::S_MUL: begin
        acc_d = mul_sum[FW-1:0];
        sat_d = mul_sat;
        mp_d  = {mp_q[tpc_pkg::MULT_W-2:0], 1'b0};
        cnt_d = cnt_q + tpc_pkg::CNT_W'(1);
        if (cnt_q == tpc_pkg::CNT_W'(tpc_pkg::MULT_W - 1)) begin
          k_d     = mul_sum[FW-1:0];
          state_d = tpc_pkg::S_SRCH;
        end
      end

      tpc_pkg::S_SRCH: begin
        if (hit) begin
          if (code_over) begin
            st_d    = tpc_pkg::ST_RANGE;
            state_d = tpc_pkg::S_DONE;
          end else begin
            dvd_d   = core_clock_q;
            rem_d   = '0;
            dsr_d   = FW'(d_q);
            cnt_d   = '0;
            state_d = tpc_pkg::S_DIV1;
          end
        end else if (d_q == tpc_pkg::D_W'(tpc_pkg::PRESCALER_STEPS)) begin
          st_d    = tpc_pkg::ST_RANGE;
          state_d = tpc_pkg::S_DONE;
        end else begin
          d_d   = d_q + tpc_pkg::D_W'(1);
          acc_d = acc_q + k_q;
        end
      end

      tpc_pkg::S_DIV1: begin
        dvd_d = div_q;
        rem_d = div_rem;
        cnt_d = cnt_q + tpc_pkg::CNT_W'(1);
        if (cnt_q == tpc_pkg::CNT_W'(CW - 1)) begin
          // core_clock / d done; divide it by f next
          rem_d   = '0;
          dsr_d   = f_q;
          cnt_d   = '0;
          state_d = tpc_pkg::S_DIV2;
        end
      end

      tpc_pkg::S_DIV2: begin
        dvd_d = div_q;
        rem_d = div_rem;
        cnt_d = cnt_q + tpc_pkg::CNT_W'(1);
        if (cnt_q == tpc_pkg::CNT_W'(CW - 1)) begin
          st_d    = tpc_pkg::ST_OK;
          state_d = tpc_pkg::S_DONE;
        end
      end

      tpc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          if (st_q == tpc_pkg::ST_OK) begin
            out_period_d = dvd_q[tpc_pkg::PERIOD_W-1:0];
            out_code_d   = code_full[tpc_pkg::CODE_W-1:0];
          end else begin
            out_period_d = '0;
            out_code_d   = '0;
          end
          state_d = tpc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpc_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q          <= f_d;
    acc_q        <= acc_d;
    sat_q        <= sat_d;
    k_q          <= k_d;
    mp_q         <= mp_d;
    d_q          <= d_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    dsr_q        <= dsr_d;
    st_q         <= st_d;
    out_period_q <= out_period_d;
    out_code_q   <= out_code_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign period_o         = out_period_q;
  assign prescaler_code_o = out_code_q;
  assign status_o         = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted but block not busy next cycle");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpc_pkg::S_SRCH) |->
      (d_q >= tpc_pkg::D_W'(1)) && (d_q <= tpc_pkg::D_W'(tpc_pkg::PRESCALER_STEPS)))
    else $error("divider search out of range");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tpc_pkg::S_DIV1) || (state_q == tpc_pkg::S_DIV2)) |-> (rem_q < dsr_q))
    else $error("division remainder not below divisor");

  a_period_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == tpc_pkg::ST_OK)) |-> (period_o <= period_limit_q))
    else $error("period exceeds the period limit");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != tpc_pkg::ST_OK)) |->
      ((period_o == '0) && (prescaler_code_o == '0)))
    else $error("failed item carries nonzero period or code");

endmodule

`default_nettype wire
